[hdl/swcg_pkg.sv]
`default_nettype none

package swcg_pkg;

    localparam int KIND_W     = 1;
    localparam int TOOL_W     = 3;
    localparam int LEN_W      = 24;
    localparam int TIME_W     = 32;
    localparam int VERDICT_W  = 3;
    localparam int CALLS_W    = 4;
    localparam int MASK_W     = 8;
    localparam int WINDOW_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    typedef logic [KIND_W-1:0]     t_kind;
    typedef logic [TOOL_W-1:0]     t_tool;
    typedef logic [LEN_W-1:0]      t_len;
    typedef logic [TIME_W-1:0]     t_time;
    typedef logic [VERDICT_W-1:0]  t_verdict;
    typedef logic [CALLS_W-1:0]    t_calls;
    typedef logic [MASK_W-1:0]     t_mask;
    typedef logic [WINDOW_W-1:0]   t_window;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    localparam t_kind KIND_CHECK  = 1'b0;
    localparam t_kind KIND_RECORD = 1'b1;

    localparam t_verdict V_ALLOW     = 3'd0;
    localparam t_verdict V_BAD_NAME  = 3'd1;
    localparam t_verdict V_DISABLED  = 3'd2;
    localparam t_verdict V_TOO_LARGE = 3'd3;
    localparam t_verdict V_RATE      = 3'd4;

    localparam t_cfg_idx CFG_ENABLE_MASK = 2'd0;
    localparam t_cfg_idx CFG_MAX_LENGTH  = 2'd1;
    localparam t_cfg_idx CFG_WINDOW      = 2'd2;

    localparam t_mask   RST_ENABLE_MASK = 8'hFF;
    localparam t_len    RST_MAX_LENGTH  = 24'd4096;
    localparam t_window RST_WINDOW      = 16'd60;

endpackage

`default_nettype wire

[hdl/sliding_window_call_guard.sv]
`default_nettype none

// Tool call guard with a per-tool sliding-window log of call timestamps.
// A record item is taken while the guard is idle and writes its time into
// the tool's ring; it yields no result. A check item that is denied early
// (no name, disabled, input too large) or that names a tool without rate
// limiting goes from idle straight to the done state. A check on a
// rate-limited tool passes through the read state and, unless the ring is
// empty, the compare state, where the expiry walk reads one stamp per
// cycle, until one is in the window or none is live, from the stamp
// RAM's single read port. Input is not ready while a check is in work; a
// finished result waits in the output register while the next item is
// taken. Configuration is always ready. The stamp RAM needs no clearing
// pass after reset, since only stamps written since reset are ever live.
module sliding_window_call_guard_core #(
    parameter int RING_SLOTS    = 8,
    parameter int LIMITED_TOOLS = 3,
    parameter int TOOL_IDS      = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire swcg_pkg::t_cfg_idx    i_cfg_index,
    input  wire swcg_pkg::t_cfg_data   i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire swcg_pkg::t_kind       i_kind,
    input  wire swcg_pkg::t_tool       i_tool_id,
    input  wire logic                  i_name_present,
    input  wire swcg_pkg::t_len        i_input_length,
    input  wire swcg_pkg::t_time       i_now_seconds,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output swcg_pkg::t_verdict         o_verdict,
    output swcg_pkg::t_calls           o_calls_in_window
);

    import swcg_pkg::*;

    localparam int HW        = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
    localparam int CW        = $clog2(RING_SLOTS + 1);
    localparam int SW        = CW + 1;
    localparam int TW        = (LIMITED_TOOLS > 1) ? $clog2(LIMITED_TOOLS) : 1;
    localparam int RAM_DEPTH = LIMITED_TOOLS * RING_SLOTS;
    localparam int RAW       = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_CMP  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]    r_state, n_state;
    t_mask         r_enable_mask;
    t_len          r_max_length;
    t_window       r_window;
    logic [HW-1:0] r_head [0:LIMITED_TOOLS-1];
    logic [HW-1:0] n_head [0:LIMITED_TOOLS-1];
    logic [CW-1:0] r_live [0:LIMITED_TOOLS-1];
    logic [CW-1:0] n_live [0:LIMITED_TOOLS-1];
    t_tool         r_tool, n_tool;
    t_time         r_now, n_now;
    logic [HW-1:0] r_slot, n_slot;
    t_verdict      r_verdict, n_verdict;
    logic [CW-1:0] r_count, n_count;
    logic          r_out_valid, n_out_valid;
    t_verdict      r_out_verdict, n_out_verdict;
    t_calls        r_out_calls, n_out_calls;

    logic           in_fire;
    logic           in_limited;
    logic           in_enabled;
    logic [TW-1:0]  in_tidx;
    logic [TW-1:0]  cur_tidx;
    logic [CW-1:0]  cur_live;
    logic [SW-1:0]  oldest_sum;
    logic [HW-1:0]  oldest_slot;
    logic [HW-1:0]  next_slot;
    t_time          age;
    logic           wr_en;
    logic [RAW-1:0] wr_addr;
    logic [RAW-1:0] rd_addr;
    t_time          rd_data;

    function automatic logic [RAW-1:0] ring_addr(input logic [TW-1:0] tidx,
                                                 input logic [HW-1:0] slot);
        ring_addr = RAW'(int'(tidx) * RING_SLOTS + int'(slot));
    endfunction

    assign o_cfg_ready       = 1'b1;
    assign o_in_ready        = (r_state == S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_verdict         = r_out_verdict;
    assign o_calls_in_window = r_out_calls;

    assign in_fire    = i_in_valid && o_in_ready;
    assign in_tidx    = i_tool_id[TW-1:0];
    assign in_limited = ({1'b0, i_tool_id} < 4'(LIMITED_TOOLS));
    assign in_enabled = ({3'b000, i_tool_id} < 6'(TOOL_IDS)) && r_enable_mask[i_tool_id];

    assign cur_tidx   = r_tool[TW-1:0];
    assign cur_live   = r_live[cur_tidx];
    assign oldest_sum = SW'(r_head[cur_tidx]) + SW'(RING_SLOTS) - SW'(cur_live);
    assign oldest_slot = (oldest_sum >= SW'(RING_SLOTS)) ?
                         HW'(oldest_sum - SW'(RING_SLOTS)) : HW'(oldest_sum);
    assign next_slot  = (r_slot == HW'(RING_SLOTS - 1)) ? '0 : r_slot + 1'b1;
    assign age        = r_now - rd_data;

    assign wr_en   = in_fire && (i_kind == KIND_RECORD) && in_limited;
    assign wr_addr = ring_addr(in_tidx, r_head[in_tidx]);

    swcg_ram #(
        .WIDTH (TIME_W),
        .DEPTH (RAM_DEPTH)
    ) u_stamp_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_now_seconds),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state       = r_state;
        n_head        = r_head;
        n_live        = r_live;
        n_tool        = r_tool;
        n_now         = r_now;
        n_slot        = r_slot;
        n_verdict     = r_verdict;
        n_count       = r_count;
        n_out_valid   = r_out_valid;
        n_out_verdict = r_out_verdict;
        n_out_calls   = r_out_calls;
        rd_addr       = ring_addr(cur_tidx, oldest_slot);

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_kind == KIND_RECORD) begin
                        if (in_limited) begin
                            n_head[in_tidx] = (r_head[in_tidx] == HW'(RING_SLOTS - 1)) ?
                                              '0 : r_head[in_tidx] + 1'b1;
                            if (r_live[in_tidx] < CW'(RING_SLOTS)) begin
                                n_live[in_tidx] = r_live[in_tidx] + 1'b1;
                            end
                        end
                    end else begin
                        n_tool  = i_tool_id;
                        n_now   = i_now_seconds;
                        n_count = '0;
                        n_state = S_DONE;
                        priority if (!i_name_present) begin
                            n_verdict = V_BAD_NAME;
                        end else if (!in_enabled) begin
                            n_verdict = V_DISABLED;
                        end else if (i_input_length > r_max_length) begin
                            n_verdict = V_TOO_LARGE;
                        end else if (in_limited) begin
                            n_state = S_RD;
                        end else begin
                            n_verdict = V_ALLOW;
                        end
                    end
                end
            end
            S_RD: begin
                if (cur_live == '0) begin
                    n_verdict = V_ALLOW;
                    n_count   = '0;
                    n_state   = S_DONE;
                end else begin
                    n_slot  = oldest_slot;
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                rd_addr = ring_addr(cur_tidx, next_slot);
                if (age > TIME_W'(r_window)) begin
                    n_live[cur_tidx] = cur_live - 1'b1;
                    if (cur_live == CW'(1)) begin
                        n_verdict = V_ALLOW;
                        n_count   = '0;
                        n_state   = S_DONE;
                    end else begin
                        n_slot = next_slot;
                    end
                end else begin
                    n_count   = cur_live;
                    n_verdict = (cur_live >= CW'(RING_SLOTS)) ? V_RATE : V_ALLOW;
                    n_state   = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid   = 1'b1;
                    n_out_verdict = r_verdict;
                    n_out_calls   = CALLS_W'(r_count);
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_enable_mask <= RST_ENABLE_MASK;
            r_max_length  <= RST_MAX_LENGTH;
            r_window      <= RST_WINDOW;
            for (int t = 0; t < LIMITED_TOOLS; t++) begin
                r_head[t] <= '0;
                r_live[t] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_head      <= n_head;
            r_live      <= n_live;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_ENABLE_MASK: r_enable_mask <= i_cfg_data[MASK_W-1:0];
                    CFG_MAX_LENGTH:  r_max_length  <= i_cfg_data[LEN_W-1:0];
                    CFG_WINDOW:      r_window      <= i_cfg_data[WINDOW_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tool        <= n_tool;
        r_now         <= n_now;
        r_slot        <= n_slot;
        r_verdict     <= n_verdict;
        r_count       <= n_count;
        r_out_verdict <= n_out_verdict;
        r_out_calls   <= n_out_calls;
    end

`ifndef NO_ASSERTIONS
    a_rate_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_verdict == V_RATE) |-> (o_calls_in_window == CALLS_W'(RING_SLOTS)))
        else $error("rate-limited verdict without a full ring");

    a_early_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_verdict == V_BAD_NAME || o_verdict == V_DISABLED ||
                         o_verdict == V_TOO_LARGE)) |-> (o_calls_in_window == '0))
        else $error("early denial reports live calls");

    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (cur_live <= CW'(RING_SLOTS)))
        else $error("live count beyond ring size");

    a_walk_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (cur_live != '0))
        else $error("expiry walk on an empty ring");

    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && (!r_out_valid || i_out_ready)) |=>
        (o_out_valid && r_state == S_IDLE))
        else $error("finished result not loaded");
`endif

endmodule

`default_nettype wire

[hdl/swcg_ram.sv]
`default_nettype none

module swcg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 24,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

[tb/sv/call_guard_checker.sv]
`timescale 1ns / 100ps

module call_guard_checker #(
    parameter int RING_SLOTS    = 8,
    parameter int LIMITED_TOOLS = 3,
    parameter int TOOL_IDS      = 8
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_valid,
    input  wire logic                i_cfg_ready,
    input  wire swcg_pkg::t_cfg_idx  i_cfg_index,
    input  wire swcg_pkg::t_cfg_data i_cfg_data,
    input  wire logic                i_in_valid,
    input  wire logic                i_in_ready,
    input  wire swcg_pkg::t_kind     i_kind,
    input  wire swcg_pkg::t_tool     i_tool_id,
    input  wire logic                i_name_present,
    input  wire swcg_pkg::t_len      i_input_length,
    input  wire swcg_pkg::t_time     i_now_seconds,
    input  wire logic                i_out_valid,
    input  wire logic                i_out_ready,
    input  wire swcg_pkg::t_verdict  i_verdict,
    input  wire swcg_pkg::t_calls    i_calls_in_window,
    output logic [31:0]              o_fail_count,
    output logic [31:0]              o_pending,
    output logic [31:0]              o_checked
);

    import swcg_pkg::*;

    typedef struct packed {
        t_verdict verdict;
        t_calls   calls;
    } t_guard_verdict;

    t_mask   cfg_mask;
    t_len    cfg_max_len;
    t_window cfg_window;

    t_time stamp_mem [LIMITED_TOOLS][RING_SLOTS];
    int    ring_head [LIMITED_TOOLS];
    int    live_cnt  [LIMITED_TOOLS];

    t_guard_verdict expected_verdicts [$];

    int unsigned mismatch_cnt = 0;
    int unsigned pending_cnt  = 0;
    int unsigned compared_cnt = 0;

    assign o_fail_count = mismatch_cnt;
    assign o_pending    = pending_cnt;
    assign o_checked    = compared_cnt;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatch_cnt++;
    endtask

    task automatic predict_call(input t_kind kind, input t_tool tool, input logic named,
                                input t_len len, input t_time now);
        t_guard_verdict res;
        int             t;
        int             oldest;
        t_time          age;
        logic           enabled;
        logic           done;
        t = int'(tool);
        if (kind == KIND_RECORD) begin
            if (t < LIMITED_TOOLS) begin
                stamp_mem[t][ring_head[t]] = now;
                ring_head[t] = (ring_head[t] + 1) % RING_SLOTS;
                if (live_cnt[t] < RING_SLOTS) begin
                    live_cnt[t]++;
                end
            end
        end else begin
            enabled = (t < TOOL_IDS) && (t < MASK_W) && cfg_mask[tool];
            res.calls = '0;
            if (!named) begin
                res.verdict = V_BAD_NAME;
            end else if (!enabled) begin
                res.verdict = V_DISABLED;
            end else if (len > cfg_max_len) begin
                res.verdict = V_TOO_LARGE;
            end else if (t < LIMITED_TOOLS) begin
                done = 1'b0;
                while (!done && live_cnt[t] > 0) begin
                    oldest = (ring_head[t] + RING_SLOTS - live_cnt[t]) % RING_SLOTS;
                    age = now - stamp_mem[t][oldest];
                    if (age > cfg_window) begin
                        live_cnt[t]--;
                    end else begin
                        done = 1'b1;
                    end
                end
                res.calls = t_calls'(live_cnt[t]);
                res.verdict = (live_cnt[t] >= RING_SLOTS) ? V_RATE : V_ALLOW;
            end else begin
                res.verdict = V_ALLOW;
            end
            expected_verdicts.push_back(res);
        end
    endtask

    always @(posedge i_clk) begin
        t_guard_verdict want;
        if (!i_rst_n) begin
            cfg_mask    = RST_ENABLE_MASK;
            cfg_max_len = RST_MAX_LENGTH;
            cfg_window  = RST_WINDOW;
            for (int t = 0; t < LIMITED_TOOLS; t++) begin
                ring_head[t] = 0;
                live_cnt[t]  = 0;
                for (int s = 0; s < RING_SLOTS; s++) begin
                    stamp_mem[t][s] = '0;
                end
            end
            expected_verdicts.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ENABLE_MASK: cfg_mask    = i_cfg_data[MASK_W-1:0];
                    CFG_MAX_LENGTH:  cfg_max_len = i_cfg_data[LEN_W-1:0];
                    CFG_WINDOW:      cfg_window  = i_cfg_data[WINDOW_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_verdicts.size() == 0) begin
                    report_mismatch($sformatf("unexpected result verdict %0d calls %0d",
                                              i_verdict, i_calls_in_window));
                end else begin
                    want = expected_verdicts.pop_front();
                    compared_cnt++;
                    if (i_verdict !== want.verdict) begin
                        report_mismatch($sformatf("verdict got %0d want %0d",
                                                  i_verdict, want.verdict));
                    end
                    if (i_calls_in_window !== want.calls) begin
                        report_mismatch($sformatf("calls_in_window got %0d want %0d",
                                                  i_calls_in_window, want.calls));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_call(i_kind, i_tool_id, i_name_present, i_input_length,
                             i_now_seconds);
            end
        end
        pending_cnt = expected_verdicts.size();
    end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

    import swcg_pkg::*;

    localparam int RING_SLOTS        = 8;
    localparam int LIMITED_TOOLS     = 3;
    localparam int TOOL_IDS          = 8;
    localparam int NUM_SETTINGS      = 7;
    localparam int CALLS_PER_SETTING = 200;
    localparam int SETTLE_CYCLES     = 16;
    localparam int STALL_LIMIT       = 4000;

    localparam t_cfg_idx CFG_UNUSED = 2'd3;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_cfg_valid;
    logic      o_cfg_ready;
    t_cfg_idx  i_cfg_index;
    t_cfg_data i_cfg_data;
    logic      i_in_valid;
    logic      o_in_ready;
    t_kind     i_kind;
    t_tool     i_tool_id;
    logic      i_name_present;
    t_len      i_input_length;
    t_time     i_now_seconds;
    logic      o_out_valid;
    logic      i_out_ready;
    t_verdict  o_verdict;
    t_calls    o_calls_in_window;

    logic [31:0] fail_count;
    logic [31:0] pending;
    logic [31:0] checked;

    int unsigned in_idle_pct;
    int unsigned out_idle_pct;
    int unsigned calls_sent;
    int unsigned cfg_writes;

    t_mask   cur_mask;
    t_len    cur_max;
    t_window cur_window;
    t_time   sim_now;

    wire in_xfer  = i_in_valid && o_in_ready;
    wire out_xfer = o_out_valid && i_out_ready;
    wire cfg_xfer = i_cfg_valid && o_cfg_ready;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    sliding_window_call_guard_core #(
        .RING_SLOTS    (RING_SLOTS),
        .LIMITED_TOOLS (LIMITED_TOOLS),
        .TOOL_IDS      (TOOL_IDS)
    ) u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_kind            (i_kind),
        .i_tool_id         (i_tool_id),
        .i_name_present    (i_name_present),
        .i_input_length    (i_input_length),
        .i_now_seconds     (i_now_seconds),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_verdict         (o_verdict),
        .o_calls_in_window (o_calls_in_window)
    );

    call_guard_checker #(
        .RING_SLOTS    (RING_SLOTS),
        .LIMITED_TOOLS (LIMITED_TOOLS),
        .TOOL_IDS      (TOOL_IDS)
    ) u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .i_in_ready        (o_in_ready),
        .i_kind            (i_kind),
        .i_tool_id         (i_tool_id),
        .i_name_present    (i_name_present),
        .i_input_length    (i_input_length),
        .i_now_seconds     (i_now_seconds),
        .i_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .i_verdict         (o_verdict),
        .i_calls_in_window (o_calls_in_window),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_checked         (checked)
    );

    task automatic send_call(input t_kind kind, input t_tool tool, input logic named,
                             input t_len len, input t_time now);
        while ($urandom_range(0, 99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_kind         <= kind;
        i_tool_id      <= tool;
        i_name_present <= named;
        i_input_length <= len;
        i_now_seconds  <= now;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        calls_sent++;
    endtask

    task automatic write_reg(input t_cfg_idx idx, input t_cfg_data data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        cfg_writes++;
    endtask

    task automatic settle_idle();
        i_in_valid <= 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic apply_setting(input int s);
        case (s)
            0: begin
                cur_mask   = 8'hFF;
                cur_max    = 24'hFF_FFFF;
                cur_window = 16'hFFFF;
            end
            1: begin
                cur_mask   = 8'h00;
                cur_max    = t_len'($urandom);
                cur_window = t_window'($urandom_range(0, 200));
            end
            2: begin
                cur_mask   = t_mask'($urandom) | 8'h07;
                cur_max    = '0;
                cur_window = '0;
            end
            default: begin
                cur_mask = t_mask'($urandom);
                if ($urandom_range(0, 1) == 1) begin
                    cur_mask = cur_mask | 8'h07;
                end
                if ($urandom_range(0, 1) == 1) begin
                    cur_max = t_len'($urandom_range(0, 8192));
                end else begin
                    cur_max = t_len'($urandom);
                end
                if ($urandom_range(0, 1) == 1) begin
                    cur_window = t_window'($urandom_range(0, 300));
                end else begin
                    cur_window = t_window'($urandom);
                end
            end
        endcase
        write_reg(CFG_ENABLE_MASK, t_cfg_data'(cur_mask));
        write_reg(CFG_MAX_LENGTH, t_cfg_data'(cur_max));
        write_reg(CFG_WINDOW, t_cfg_data'(cur_window));
        if (s == 2) begin
            write_reg(CFG_UNUSED, t_cfg_data'($urandom));
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_call();
        int    pick;
        t_kind kind;
        t_tool tool;
        logic  named;
        t_len  len;
        if ($urandom_range(0, 49) == 0) begin
            sim_now = $urandom;
        end else if ($urandom_range(0, 9) == 0) begin
            sim_now = sim_now + cur_window + $urandom_range(0, 2);
        end else begin
            sim_now = sim_now + $urandom_range(0, (int'(cur_window) >> 3) + 1);
        end
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            kind  = KIND_RECORD;
            tool  = ($urandom_range(0, 9) == 0) ? t_tool'($urandom_range(0, 7))
                                                : t_tool'($urandom_range(0, 2));
            named = 1'($urandom);
            len   = t_len'($urandom);
        end else if (pick < 85) begin
            kind  = KIND_CHECK;
            tool  = ($urandom_range(0, 3) == 0) ? t_tool'($urandom_range(0, 7))
                                                : t_tool'($urandom_range(0, 2));
            named = 1'b1;
            case ($urandom_range(0, 5))
                0:       len = cur_max;
                1:       len = cur_max + 24'd1;
                default: len = t_len'($urandom_range(0, int'(cur_max)));
            endcase
        end else begin
            kind  = t_kind'($urandom);
            tool  = t_tool'($urandom);
            named = 1'($urandom);
            len   = t_len'($urandom);
        end
        send_call(kind, tool, named, len, sim_now);
    endtask

    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (in_xfer || out_xfer || cfg_xfer) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        i_rst_n        = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = CFG_ENABLE_MASK;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_kind         = KIND_CHECK;
        i_tool_id      = '0;
        i_name_present = 1'b0;
        i_input_length = '0;
        i_now_seconds  = '0;
        in_idle_pct    = 18;
        out_idle_pct   = 82;
        calls_sent     = 0;
        cfg_writes     = 0;
        cur_mask       = RST_ENABLE_MASK;
        cur_max        = RST_MAX_LENGTH;
        cur_window     = RST_WINDOW;
        sim_now        = $urandom;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_call(KIND_CHECK, 3'd3, 1'b1, 24'd4096, 32'd100);
        send_call(KIND_CHECK, 3'd4, 1'b1, 24'd4097, 32'd100);
        send_call(KIND_CHECK, 3'd6, 1'b0, 24'hFF_FFFF, 32'd100);
        send_call(KIND_CHECK, 3'd0, 1'b1, 24'd0, 32'd100);
        // fill tool 0 across the time wrap
        for (int i = 0; i < RING_SLOTS; i++) begin
            send_call(KIND_RECORD, 3'd0, 1'b0, 24'hFF_FFFF, 32'hFFFF_FFF8 + i);
        end
        send_call(KIND_CHECK, 3'd0, 1'b1, 24'd0, 32'd3);
        send_call(KIND_RECORD, 3'd0, 1'b1, 24'd0, 32'd4);
        send_call(KIND_CHECK, 3'd0, 1'b1, 24'd0, 32'd4);
        send_call(KIND_RECORD, 3'd1, 1'b1, 24'd0, 32'd1000);
        send_call(KIND_CHECK, 3'd1, 1'b1, 24'd10, 32'd1060);
        send_call(KIND_CHECK, 3'd1, 1'b1, 24'd10, 32'd1061);
        send_call(KIND_RECORD, 3'd5, 1'b1, 24'd0, 32'd2000);
        send_call(KIND_CHECK, 3'd5, 1'b1, 24'd0, 32'd2000);
        send_call(KIND_CHECK, 3'd0, 1'b1, 24'd0, 32'h8000_0000);
        send_call(KIND_CHECK, 3'd2, 1'b1, 24'hFF_FFFF, 32'h8000_0000);
        send_call(KIND_RECORD, 3'd7, 1'b0, 24'hFF_FFFF, 32'hFFFF_FFFF);
        send_call(KIND_CHECK, 3'd7, 1'b1, 24'd0, 32'hFFFF_FFFF);

        for (int s = 0; s < NUM_SETTINGS; s++) begin
            settle_idle();
            if (s == 3) begin
                in_idle_pct  = 82;
                out_idle_pct = 18;
            end else if (s == 5) begin
                in_idle_pct  = 0;
                out_idle_pct = 0;
            end
            apply_setting(s);
            repeat (CALLS_PER_SETTING) random_call();
        end
        settle_idle();

        $display("Run covered %0d calls and %0d compared verdicts, %0d register writes",
                 calls_sent, checked, cfg_writes);
        $display("over %0d register settings and three flow-control phases", NUM_SETTINGS);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
